[rtl/stable_priority_queue_assert.svh]
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPQ_ASSERT_IMPL(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("spq assertion failed");

// condition implies consequence in the next cycle
`define SPQ_ASSERT_NEXT(lbl, cond, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("spq assertion failed");

`endif

[rtl/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// types, codes and sizes shared by the stable priority queue
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_PROC = 2'd1;
    localparam logic [1:0] REQ_LIST = 2'd2;

    localparam logic [2:0] PRIO_MIN = 3'd1;
    localparam logic [2:0] PRIO_MAX = 3'd5;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_BADPRIO   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_PROCESSED = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;
    localparam logic [2:0] ST_LISTED    = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] entry_id;
        logic [31:0] name_tag;
        logic [2:0]  priority_req;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_id;
        logic [31:0] out_tag;
        logic [2:0]  out_priority;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] tag;
        logic [2:0]  prio;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_OUT,
        S_LIST
    } t_state;

    typedef enum logic [1:0] {
        RES_ADD,
        RES_EMPTY,
        RES_PROC,
        RES_LIST
    } t_res_sel;

    typedef struct packed {
        logic     load_req;
        logic     scan_step;
        logic     idx_inc;
        logic     idx_clr;
        logic     res_load;
        t_res_sel res_sel;
        logic     insert;
        logic     pop;
    } t_cmd;

    typedef struct packed {
        logic [1:0] in_req;
        logic       empty;
        logic       scan_done;
        logic       add_ok;
        logic       res_last;
    } t_sts;

endpackage

`default_nettype wire

[rtl/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// entry store, scan registers, fill count and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "stable_priority_queue_assert.svh"

module spq_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire spq_pkg::t_in_item i_in,
    input  wire spq_pkg::t_cmd     i_cmd,
    output spq_pkg::t_sts          o_sts,
    output spq_pkg::t_out_item     o_out
);
    import spq_pkg::*;

    t_entry          r_slots [DEPTH];
    t_in_item        r_req;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_pos;
    logic            r_pos_found;
    logic            r_dup;
    t_out_item       r_res;
    t_out_item       n_res;
    t_entry          rd_entry;
    t_entry          new_entry;
    logic [2:0]      add_status;
    logic            list_last;

    assign rd_entry  = r_slots[r_idx[IDX_W-1:0]];
    assign new_entry = '{id: r_req.entry_id, tag: r_req.name_tag, prio: r_req.priority_req};
    assign list_last = ((r_idx + CNT_W'(1)) == r_fill);

    always_comb begin
        priority if (r_dup) begin
            add_status = ST_DUP;
        end else if (r_req.priority_req < PRIO_MIN || r_req.priority_req > PRIO_MAX) begin
            add_status = ST_BADPRIO;
        end else if (r_fill >= CNT_W'(DEPTH)) begin
            add_status = ST_FULL;
        end else begin
            add_status = ST_ADDED;
        end
    end

    always_comb begin
        n_res = '0;
        unique case (i_cmd.res_sel)
            RES_ADD: begin
                n_res.status = add_status;
                n_res.last   = 1'b1;
            end
            RES_EMPTY: begin
                n_res.status = ST_EMPTY;
                n_res.last   = 1'b1;
            end
            RES_PROC: begin
                n_res.status       = ST_PROCESSED;
                n_res.out_id       = rd_entry.id;
                n_res.out_tag      = rd_entry.tag;
                n_res.out_priority = rd_entry.prio;
                n_res.last         = 1'b1;
            end
            RES_LIST: begin
                n_res.status       = ST_LISTED;
                n_res.out_id       = rd_entry.id;
                n_res.out_tag      = rd_entry.tag;
                n_res.out_priority = rd_entry.prio;
                n_res.last         = list_last;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.insert) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (i_cmd.pop) begin
                r_fill <= r_fill - CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    // request latch, scan and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req       <= i_in;
            r_dup       <= 1'b0;
            r_pos_found <= 1'b0;
            r_pos       <= r_fill;
        end else if (i_cmd.scan_step) begin
            if (rd_entry.id == r_req.entry_id) begin
                r_dup <= 1'b1;
            end
            if (!r_pos_found && rd_entry.prio > r_req.priority_req) begin
                r_pos       <= r_idx;
                r_pos_found <= 1'b1;
            end
        end
        if (i_cmd.res_load) begin
            r_res <= n_res;
        end
    end

    // entry store, kept in service order
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            if (r_pos == '0) begin
                r_slots[0] <= new_entry;
            end
            for (int j = 1; j < DEPTH; j++) begin
                if (CNT_W'(j) == r_pos) begin
                    r_slots[j] <= new_entry;
                end else if (CNT_W'(j) > r_pos) begin
                    r_slots[j] <= r_slots[j-1];
                end
            end
        end else if (i_cmd.pop) begin
            for (int j = 0; j < DEPTH - 1; j++) begin
                r_slots[j] <= r_slots[j+1];
            end
        end
    end

    assign o_sts.in_req    = i_in.req_type;
    assign o_sts.empty     = (r_fill == '0);
    assign o_sts.scan_done = (r_idx >= r_fill);
    assign o_sts.add_ok    = (add_status == ST_ADDED);
    assign o_sts.res_last  = r_res.last;
    assign o_out           = r_res;

    `SPQ_ASSERT_IMPL(a_fill_bound, 1'b1, r_fill <= CNT_W'(DEPTH))
    `SPQ_ASSERT_IMPL(a_insert_not_full, i_cmd.insert, r_fill < CNT_W'(DEPTH))
    `SPQ_ASSERT_IMPL(a_pop_not_empty, i_cmd.pop, r_fill != '0)
    `SPQ_ASSERT_NEXT(a_insert_grows, i_cmd.insert, r_fill == $past(r_fill) + CNT_W'(1))

endmodule

`default_nettype wire

[rtl/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// request sequencer: scan, insert, pop and result beats
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    input  wire spq_pkg::t_sts i_sts,
    output spq_pkg::t_cmd      o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (i_sts.in_req)
                        REQ_ADD: begin
                            o_cmd.load_req = 1'b1;
                            n_state        = S_SCAN;
                        end
                        REQ_PROC: begin
                            o_cmd.res_load = 1'b1;
                            if (i_sts.empty) begin
                                o_cmd.res_sel = RES_EMPTY;
                            end else begin
                                o_cmd.res_sel = RES_PROC;
                                o_cmd.pop     = 1'b1;
                            end
                            n_state = S_OUT;
                        end
                        REQ_LIST: begin
                            o_cmd.res_load = 1'b1;
                            if (i_sts.empty) begin
                                o_cmd.res_sel = RES_EMPTY;
                                n_state       = S_OUT;
                            end else begin
                                o_cmd.res_sel = RES_LIST;
                                o_cmd.idx_inc = 1'b1;
                                n_state       = S_LIST;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_ADD;
                    o_cmd.insert   = i_sts.add_ok;
                    o_cmd.idx_clr  = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    o_cmd.idx_inc   = 1'b1;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_LIST: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.res_last) begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = S_IDLE;
                    end else begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_LIST;
                        o_cmd.idx_inc  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_priority_queue
// add: the sequencer takes one scan step per stored entry, then registers the result
// process: result valid in the cycle after the request beat; list: one beat per cycle while the result side is ready
// one request at a time; next request taken the cycle after its last result beat
// reset clears the fill count, scan index and sequencer; entry store holds no reset value
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire spq_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output spq_pkg::t_out_item      o_out
);
    import spq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    spq_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

[test/tb_stable_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// drives add, process and list requests through the valid/ready request port
// and compares every result beat with a priority queue kept alongside the
// block; a short table of directed requests opens the run, then random
// traffic that swings between filling the queue and draining it, with random
// gaps on both ports and a long result-side hold-off that backs up requests
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_ITEMS = 434;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int HOLD_OFF_AT  = 1500;
    localparam int HOLD_OFF_LEN = 400;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        t_in_item   req;
        bit         typed;
        logic [2:0] status;
    } t_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_beat   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_beat;

    t_entry    q_slots [DEPTH];
    int        q_fill = 0;
    t_out_item req_beats [$];
    t_out_item due_beats [$];
    t_row      dir_rows [$];
    int        errors    = 0;
    int        cycle_cnt = 0;

    always #CLK_HALF clk = ~clk;

    stable_priority_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_beat)
    );

    function automatic t_out_item make_beat(logic [2:0] st, t_entry e, logic lst);
        t_out_item b;
        b.status       = st;
        b.out_id       = e.id;
        b.out_tag      = e.tag;
        b.out_priority = e.prio;
        b.last         = lst;
        return b;
    endfunction

    // result beats of one request, updating the queue copy
    function automatic void serve_request(t_in_item r);
        t_entry     none;
        t_entry     e;
        logic [2:0] st;
        int         pos;
        none = '0;
        req_beats.delete();
        case (r.req_type)
            REQ_ADD: begin
                st = ST_ADDED;
                for (int k = 0; k < q_fill; k++)
                    if (q_slots[k].id == r.entry_id) st = ST_DUP;
                if (st == ST_ADDED && (r.priority_req < PRIO_MIN || r.priority_req > PRIO_MAX))
                    st = ST_BADPRIO;
                else if (st == ST_ADDED && q_fill >= DEPTH)
                    st = ST_FULL;
                if (st == ST_ADDED) begin
                    pos = 0;
                    while (pos < q_fill && q_slots[pos].prio <= r.priority_req) pos++;
                    for (int k = q_fill; k > pos; k--) q_slots[k] = q_slots[k - 1];
                    e.id  = r.entry_id;
                    e.tag = r.name_tag;
                    e.prio = r.priority_req;
                    q_slots[pos] = e;
                    q_fill++;
                end
                req_beats.push_back(make_beat(st, none, 1'b1));
            end
            REQ_PROC: begin
                if (q_fill == 0) begin
                    req_beats.push_back(make_beat(ST_EMPTY, none, 1'b1));
                end else begin
                    req_beats.push_back(make_beat(ST_PROCESSED, q_slots[0], 1'b1));
                    for (int k = 1; k < q_fill; k++) q_slots[k - 1] = q_slots[k];
                    q_fill--;
                end
            end
            REQ_LIST: begin
                if (q_fill == 0)
                    req_beats.push_back(make_beat(ST_EMPTY, none, 1'b1));
                for (int k = 0; k < q_fill; k++)
                    req_beats.push_back(make_beat(ST_LISTED, q_slots[k], k == q_fill - 1));
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void dir_row(logic [1:0] rq, logic [15:0] id, logic [31:0] tag,
                                    logic [2:0] pr, bit typed, logic [2:0] st);
        t_row row;
        row.req.req_type     = rq;
        row.req.entry_id     = id;
        row.req.name_tag     = tag;
        row.req.priority_req = pr;
        row.typed            = typed;
        row.status           = st;
        dir_rows.push_back(row);
    endfunction

    function automatic void build_rows();
        dir_row(REQ_PROC, 16'h5A5A, 32'h0000_0000, 3'd3, 1'b1, ST_EMPTY);
        dir_row(REQ_LIST, 16'h0000, 32'h0000_0000, 3'd0, 1'b1, ST_EMPTY);
        dir_row(REQ_NONE, 16'hFFFF, 32'hFFFF_FFFF, 3'd7, 1'b0, ST_ADDED);
        dir_row(REQ_ADD,  16'hFFFF, 32'h1234_5678, 3'd0, 1'b1, ST_BADPRIO);
        dir_row(REQ_ADD,  16'h0000, 32'hFFFF_FFFF, PRIO_MAX, 1'b1, ST_ADDED);
        dir_row(REQ_ADD,  16'hFFFF, 32'h0000_0000, PRIO_MIN, 1'b1, ST_ADDED);
        dir_row(REQ_LIST, 16'h0000, 32'h0000_0000, 3'd0, 1'b0, ST_ADDED);
        for (int k = 0; k < DEPTH - 2; k++)
            dir_row(REQ_ADD, 16'h0100 + 16'(k), $urandom, 3'(PRIO_MIN + k % 5), 1'b0, ST_ADDED);
        // duplicate wins over bad priority and full, bad priority over full
        dir_row(REQ_ADD,  16'h0000, 32'h0000_0000, 3'd0, 1'b1, ST_DUP);
        dir_row(REQ_ADD,  16'h8000, 32'h0000_0000, 3'd7, 1'b1, ST_BADPRIO);
        dir_row(REQ_ADD,  16'h8001, 32'hA5A5_A5A5, PRIO_MIN, 1'b1, ST_FULL);
        dir_row(REQ_LIST, 16'h0000, 32'h0000_0000, 3'd0, 1'b0, ST_ADDED);
        dir_row(REQ_PROC, 16'h0000, 32'h0000_0000, 3'd0, 1'b0, ST_ADDED);
    endfunction

    // alternating fill and drain phases of 60 requests
    function automatic t_in_item random_req(int n);
        t_in_item r;
        int       pick;
        bit       filling;
        filling        = ((n / 60) % 2) == 0;
        r.entry_id     = 16'($urandom);
        r.name_tag     = $urandom;
        r.priority_req = 3'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            r.req_type = REQ_NONE;
        end else if (pick < (filling ? 70 : 35)) begin
            r.req_type = REQ_ADD;
            pick = $urandom_range(0, 99);
            if (pick < 12 && q_fill > 0)
                r.entry_id = q_slots[$urandom_range(0, q_fill - 1)].id;
            else if (pick < 45)
                r.entry_id = 16'($urandom_range(0, 63));
            if ($urandom_range(0, 9) == 0)
                r.priority_req = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'(5 + $urandom_range(1, 2));
            else
                r.priority_req = 3'($urandom_range(PRIO_MIN, PRIO_MAX));
        end else if (pick < (filling ? 85 : 80)) begin
            r.req_type = REQ_PROC;
        end else begin
            r.req_type = REQ_LIST;
        end
        return r;
    endfunction

    task automatic send_req(t_row row, bit steady);
        int        gap;
        t_entry    none;
        none = '0;
        gap  = pick_gap(steady);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= row.req;
        do @(posedge clk); while (in_ready !== 1'b1);
        serve_request(row.req);
        if (row.typed)
            due_beats.push_back(make_beat(row.status, none, 1'b1));
        else
            foreach (req_beats[k]) due_beats.push_back(req_beats[k]);
    endtask

    task automatic compare_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", fname, want, got);
            errors++;
        end
    endtask

    task automatic check_beat(t_out_item got);
        t_out_item want;
        if (due_beats.size() == 0) begin
            $error("result beat with nothing due: status %0d id %0h", got.status, got.out_id);
            errors++;
        end else begin
            want = due_beats.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_id", 32'(want.out_id), 32'(got.out_id));
            compare_field("out_tag", want.out_tag, got.out_tag);
            compare_field("out_priority", 32'(want.out_priority), 32'(got.out_priority));
            compare_field("last", 32'(want.last), 32'(got.last));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
            check_beat(out_beat);
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result-side back-pressure with its own cycle count
    initial begin : result_side
        int wait_left;
        int hold_left;
        int clk_seen;
        wait_left = 0;
        hold_left = 0;
        clk_seen  = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            clk_seen++;
            if (clk_seen == HOLD_OFF_AT || clk_seen == 3 * HOLD_OFF_AT)
                hold_left = HOLD_OFF_LEN;
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if ((clk_seen % 1000) > 200 && $urandom_range(0, 2) == 0)
                    wait_left = pick_gap(1'b0);
            end
        end
    end

    initial begin : request_side
        t_row row;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        build_rows();
        foreach (dir_rows[n]) send_req(dir_rows[n], 1'b0);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            row.req    = random_req(n);
            row.typed  = 1'b0;
            row.status = ST_ADDED;
            send_req(row, (n % 120) < 20);
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
